/* hdl/http_request_line_checker_defines.svh */
// Assertion macros shared by the request line checker modules.
`ifndef HTTP_REQUEST_LINE_CHECKER_DEFINES_SVH
`define HTTP_REQUEST_LINE_CHECKER_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define HRLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define HRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/hrlc_pkg.sv */
// Types, constants and helper functions for the request line checker.
`timescale 1ns / 1ps
package hrlc_pkg;

    typedef enum logic [1:0] {
        ST_OK                  = 2'd0,
        ST_BAD_REQUEST         = 2'd1,
        ST_NOT_IMPLEMENTED     = 2'd2,
        ST_VERSION_UNSUPPORTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        METH_GET     = 2'd0,
        METH_POST    = 2'd1,
        METH_DELETE  = 2'd2,
        METH_UNKNOWN = 2'd3
    } method_t;

    typedef struct packed {
        status_t status;
        method_t method_kind;
    } result_t;

    typedef struct packed {
        logic [1:0] space_count;
        logic [3:0] token_position;
        logic       path_seen;
        logic       path_bad;
        logic [2:0] method_candidates;
        logic [1:0] version_candidates;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        space_count:        2'd0,
        token_position:     4'd0,
        path_seen:          1'b0,
        path_bad:           1'b0,
        method_candidates:  3'b111,
        version_candidates: 2'b11
    };

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] CTRL_MAX   = 8'd31;
    localparam logic [7:0] DEL_CHAR   = 8'd127;

    localparam logic [1:0] SPACE_MAX = 2'd3;
    localparam logic [3:0] POS_MAX   = 4'd15;

    localparam int NUM_METHODS  = 3;
    localparam int NUM_VERSIONS = 2;

    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{4'd3, 4'd4, 4'd6};
    localparam logic [3:0] VERSION_LEN = 4'd8;

    // Rows padded with zeros to eight bytes; the length test masks the padding.
    localparam logic [7:0] METHOD_TEXT [NUM_METHODS][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00}
    };

    localparam logic [7:0] VERSION_TEXT [NUM_VERSIONS][8] = '{
        '{"H", "T", "T", "P", "/", "1", ".", "1"},
        '{"H", "T", "T", "P", "/", "1", ".", "0"}
    };

    function automatic logic path_byte_ok(logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if ((c >= "0") && (c <= "9")) ok = 1'b1;
        if ((c >= "A") && (c <= "Z")) ok = 1'b1;
        if ((c >= "a") && (c <= "z")) ok = 1'b1;
        if ((c == "-") || (c == ".") || (c == "_") || (c == "~") ||
            (c == "/") || (c == "%") || (c == "?") || (c == "=")) ok = 1'b1;
        if ((c <= CTRL_MAX) || (c >= DEL_CHAR)) ok = 1'b0;
        return ok;
    endfunction

    // Bit k set when method k has exactly the given length.
    function automatic logic [2:0] method_len_mask(logic [3:0] len);
        logic [2:0] m;
        for (int k = 0; k < NUM_METHODS; k++) begin
            m[k] = (METHOD_LEN[k] == len);
        end
        return m;
    endfunction

endpackage

/* hdl/hrlc_req_if.sv */
// Request channel: one byte of the request line with its final-byte flag.
`timescale 1ns / 1ps
interface hrlc_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       last_byte;

    modport source (output valid, output line_byte, output last_byte, input ready);
    modport sink   (input valid, input line_byte, input last_byte, output ready);
endinterface

/* hdl/hrlc_res_if.sv */
// Result channel: status and method kind of one request line.
`timescale 1ns / 1ps
interface hrlc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] method_kind;

    modport source (output valid, output status, output method_kind, input ready);
    modport sink   (input valid, input status, input method_kind, output ready);
endinterface

/* hdl/hrlc_scanner.sv */
// Per-byte scan state and the verdict logic for the final byte.
`timescale 1ns / 1ps
`include "http_request_line_checker_defines.svh"
module hrlc_scanner (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       line_byte,
    input  logic             last_byte,
    output hrlc_pkg::result_t result
);
    import hrlc_pkg::*;

    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t upd;
    logic [2:0]  mc_final;
    method_t     kind;
    status_t     status;
    logic        is_space;

    always_comb begin
        upd      = state_reg;
        is_space = (line_byte == SPACE_CHAR);
        if (is_space) begin
            if (state_reg.space_count == 2'd0) begin
                upd.method_candidates = state_reg.method_candidates
                                      & method_len_mask(state_reg.token_position);
            end
            if (state_reg.space_count != SPACE_MAX) begin
                upd.space_count = state_reg.space_count + 2'd1;
            end
            upd.token_position = 4'd0;
        end else begin
            case (state_reg.space_count)
                2'd0: begin
                    for (int k = 0; k < NUM_METHODS; k++) begin
                        if (!((state_reg.token_position < METHOD_LEN[k]) &&
                              (METHOD_TEXT[k][state_reg.token_position[2:0]] == line_byte))) begin
                            upd.method_candidates[k] = 1'b0;
                        end
                    end
                end
                2'd1: begin
                    if ((!state_reg.path_seen && (line_byte != SLASH_CHAR)) ||
                        !path_byte_ok(line_byte)) begin
                        upd.path_bad = 1'b1;
                    end
                    upd.path_seen = 1'b1;
                end
                2'd2: begin
                    for (int k = 0; k < NUM_VERSIONS; k++) begin
                        if (!((state_reg.token_position < VERSION_LEN) &&
                              (VERSION_TEXT[k][state_reg.token_position[2:0]] == line_byte))) begin
                            upd.version_candidates[k] = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (state_reg.token_position != POS_MAX) begin
                upd.token_position = state_reg.token_position + 4'd1;
            end
        end
    end

    // Verdict, formed from the state as it stands after this byte.
    always_comb begin
        mc_final = upd.method_candidates;
        if (upd.space_count == 2'd0) begin
            mc_final = mc_final & method_len_mask(upd.token_position);
        end
        if (mc_final[0])      kind = METH_GET;
        else if (mc_final[1]) kind = METH_POST;
        else if (mc_final[2]) kind = METH_DELETE;
        else                  kind = METH_UNKNOWN;

        if ((upd.space_count != 2'd2) || !upd.path_seen || upd.path_bad) begin
            status = ST_BAD_REQUEST;
        end else if (kind == METH_UNKNOWN) begin
            status = ST_NOT_IMPLEMENTED;
        end else if ((upd.token_position != VERSION_LEN) ||
                     (upd.version_candidates == 2'b00)) begin
            status = ST_VERSION_UNSUPPORTED;
        end else begin
            status = ST_OK;
        end
        result.status      = status;
        result.method_kind = kind;
    end

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            state_next = last_byte ? SCAN_RESET : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= SCAN_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    `HRLC_ASSERT_NEXT(a_clear_after_last, clk, rst_n, accept && last_byte,
                      state_reg == SCAN_RESET)
    `HRLC_ASSERT_NEXT(a_space_counts, clk, rst_n,
                      accept && !last_byte && (line_byte == SPACE_CHAR) &&
                      (state_reg.space_count != SPACE_MAX),
                      (state_reg.token_position == 4'd0) &&
                      (state_reg.space_count == $past(state_reg.space_count) + 2'd1))
endmodule

/* hdl/hrlc_out_stage.sv */
// Result register that decouples the scanner from the result channel.
`timescale 1ns / 1ps
module hrlc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hrlc_pkg::result_t push_data,
    output logic              room,
    hrlc_res_if.source        res
);
    import hrlc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // A new result may enter when the register is empty or drains this cycle.
    assign room = !valid_reg || res.ready;

    always_comb begin
        valid_next = valid_reg;
        if (res.ready) valid_next = 1'b0;
        if (push)      valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign res.valid       = valid_reg;
    assign res.status      = data_reg.status;
    assign res.method_kind = data_reg.method_kind;
endmodule

/* hdl/http_request_line_checker.sv */
// Top level of the request line checker: scanner plus result register.
// The result of a line is registered and becomes valid in the cycle after its final byte is accepted.
// Throughput: one byte per cycle, lines back to back; only a stalled result channel
// holding an untaken result stops bytes being taken.
// Reset: rst_n clears the scan state to its start values and empties the result register.
`timescale 1ns / 1ps
`include "http_request_line_checker_defines.svh"
module http_request_line_checker (
    input  logic       clk,
    input  logic       rst_n,
    hrlc_req_if.sink   request,
    hrlc_res_if.source response
);
    import hrlc_pkg::*;

    // The scanner keeps the per-token state; every accepted request byte
    // updates it. On the final byte the verdict is formed from the updated
    // state and loaded into the result register, while the scan state returns
    // to its start values so the next line can begin at once.
    logic    accept;
    logic    room;
    result_t verdict;

    // Bytes are taken whenever the result register can absorb a result. A
    // byte is therefore held back only while the downstream side is stalled
    // with a result waiting.
    assign request.ready = room;
    assign accept        = request.valid && request.ready;

    hrlc_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .line_byte (request.line_byte),
        .last_byte (request.last_byte),
        .result    (verdict)
    );

    // The result register parts the two channels so a waiting result does
    // not hold up the next line's bytes while the consumer is taking it.
    hrlc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && request.last_byte),
        .push_data (verdict),
        .room      (room),
        .res       (response)
    );

    // A final byte always yields a result in the following cycle.
    `HRLC_ASSERT_NEXT(a_result_follows_last, clk, rst_n,
                      accept && request.last_byte, response.valid)
    // Request bytes are refused only behind a stalled, occupied result register.
    `HRLC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n,
                     !request.ready, response.valid && !response.ready)
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the HTTP request line checker.
`timescale 1ns / 1ps
module tb_top;
    import hrlc_pkg::*;

    // Upper bound on the run.
    localparam int CYCLE_LIMIT = 300000;
    localparam int BYTE_TARGET = 1600;
    localparam int QUIET_TAIL  = 200;
    localparam int DRAIN_WAIT  = 10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam int N_VERBS  = 3;
    localparam int N_PROTOS = 2;
    localparam logic [3:0] VERB_LEN [N_VERBS] = '{4'd3, 4'd4, 4'd6};
    localparam logic [3:0] PROTO_LEN = 4'd8;
    localparam logic [7:0] VERB_CHARS [N_VERBS][6] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E"}
    };
    localparam logic [7:0] PROTO_CHARS [N_PROTOS][8] = '{
        '{"H", "T", "T", "P", "/", "1", ".", "1"},
        '{"H", "T", "T", "P", "/", "1", ".", "0"}
    };

    // One byte of a request line waiting to be sent. A held byte is only
    // sent once every outstanding verdict has come back; a calm byte is sent
    // with no idling on either side.
    typedef struct {
        logic [7:0] octet;
        logic       fin;
        logic       hold;
        logic       calm;
    } line_octet_t;

    typedef struct {
        status_t st;
        method_t kind;
    } verdict_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte  = 8'h00;
    logic       drv_last  = 1'b0;
    logic       drv_ready = 1'b0;

    hrlc_req_if request_ch ();
    hrlc_res_if result_ch ();

    assign request_ch.valid     = drv_valid;
    assign request_ch.line_byte = drv_byte;
    assign request_ch.last_byte = drv_last;
    assign result_ch.ready      = drv_ready;

    http_request_line_checker uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    line_octet_t octet_backlog [$];
    logic [7:0]  line_buf [$];
    verdict_t    line_verdicts [$];
    string       path_set =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~/%?=";

    int   cycle_count = 0;
    int   fault_count = 0;
    int   send_gap    = 0;
    int   take_gap    = 0;
    int   idle_mode   = 0;
    logic octet_taken = 1'b0;
    logic quiet_tail  = 1'b0;

    // Scanner state of the predictor, kept at the block's own widths.
    logic [1:0] sp_seen       = 2'd0;
    logic [3:0] tok_idx       = 4'd0;
    logic       path_nonempty = 1'b0;
    logic       path_err      = 1'b0;
    logic [2:0] verb_live     = 3'b111;
    logic [1:0] proto_live    = 2'b11;

    // Drops every method whose name length differs from the token length.
    function automatic logic [2:0] keep_len(logic [2:0] live, logic [3:0] len);
        for (int k = 0; k < N_VERBS; k++) begin
            if (VERB_LEN[k] != len) live[k] = 1'b0;
        end
        return live;
    endfunction

    // Advances the predictor by one accepted request. On the final byte of a
    // line the verdict is queued and the scanner returns to its start state.
    task automatic scan_byte(input logic [7:0] c, input logic fin);
        logic [3:0] pos;
        logic [2:0] verbs;
        logic       char_ok;
        status_t    st;
        method_t    kind;
        verdict_t   fresh;
        pos = tok_idx;
        if (c == CH_SPACE) begin
            // The method token is closed by the first space, so its length
            // is known only now.
            if (sp_seen == 2'd0) verb_live = keep_len(verb_live, tok_idx);
            if (sp_seen != 2'd3) sp_seen = sp_seen + 2'd1;
            tok_idx = 4'd0;
        end else begin
            case (sp_seen)
                2'd0:
                begin
                    for (int k = 0; k < N_VERBS; k++) begin
                        if (pos >= VERB_LEN[k] || VERB_CHARS[k][pos] != c)
                            verb_live[k] = 1'b0;
                    end
                end
                2'd1:
                begin
                    char_ok = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                              (c >= "a" && c <= "z") || c == "-" || c == "." ||
                              c == "_" || c == "~" || c == "/" || c == "%" ||
                              c == "?" || c == "=";
                    if (!path_nonempty && c != CH_SLASH) path_err = 1'b1;
                    if (!char_ok) path_err = 1'b1;
                    path_nonempty = 1'b1;
                end
                2'd2:
                begin
                    for (int k = 0; k < N_PROTOS; k++) begin
                        if (pos >= PROTO_LEN || PROTO_CHARS[k][pos] != c)
                            proto_live[k] = 1'b0;
                    end
                end
                default:
                begin
                    // Tokens after the third space are not looked at.
                end
            endcase
            if (tok_idx != 4'd15) tok_idx = tok_idx + 4'd1;
        end

        if (fin) begin
            // A line with no space is all method, still open at this point.
            verbs = verb_live;
            if (sp_seen == 2'd0) verbs = keep_len(verbs, tok_idx);
            if (verbs[0]) kind = METH_GET;
            else if (verbs[1]) kind = METH_POST;
            else if (verbs[2]) kind = METH_DELETE;
            else kind = METH_UNKNOWN;

            if (sp_seen != 2'd2 || !path_nonempty || path_err) st = ST_BAD_REQUEST;
            else if (kind == METH_UNKNOWN) st = ST_NOT_IMPLEMENTED;
            else if (tok_idx != PROTO_LEN || proto_live == 2'b00)
                st = ST_VERSION_UNSUPPORTED;
            else st = ST_OK;
            fresh.st   = st;
            fresh.kind = kind;
            line_verdicts.insert(line_verdicts.size(), fresh);

            sp_seen       = 2'd0;
            tok_idx       = 4'd0;
            path_nonempty = 1'b0;
            path_err      = 1'b0;
            verb_live     = 3'b111;
            proto_live    = 2'b11;
        end
    endtask

    // Moves the line being built into the backlog, flagging its last byte.
    task automatic commit_line(input logic hold);
        line_octet_t item;
        for (int i = 0; i < line_buf.size(); i++) begin
            item.octet = line_buf[i];
            item.fin   = (i == line_buf.size() - 1);
            item.hold  = hold && (i == 0);
            item.calm  = 1'b0;
            octet_backlog.insert(octet_backlog.size(), item);
        end
        line_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.insert(line_buf.size(), s[i]);
    endtask

    // Builds one random line. Most lines follow the request line grammar with
    // random content and light damage; the rest are raw noise.
    task automatic add_random_line(input logic hold);
        int         shape;
        int         verb;
        int         n;
        logic [7:0] rb;
        shape = $urandom_range(0, 99);
        if (shape < 15) begin
            n = $urandom_range(1, 20);
            repeat (n) begin
                rb = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 4) == 0) rb = CH_SPACE;
                line_buf.insert(line_buf.size(), rb);
            end
        end else begin
            verb = $urandom_range(0, 4);
            if (verb < N_VERBS) begin
                for (int k = 0; k < VERB_LEN[verb]; k++)
                    line_buf.insert(line_buf.size(), VERB_CHARS[verb][k]);
            end else begin
                // Unknown or over-long method names, past the saturation point.
                n = $urandom_range(0, 18);
                repeat (n) begin
                    rb = 8'h41 + 8'($urandom_range(0, 25));
                    line_buf.insert(line_buf.size(), rb);
                end
            end
            if (shape >= 20) line_buf.insert(line_buf.size(), CH_SPACE);

            if ($urandom_range(0, 9) != 0) line_buf.insert(line_buf.size(), CH_SLASH);
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0) rb = 8'($urandom_range(0, 255));
                else rb = path_set[$urandom_range(0, path_set.len() - 1)];
                line_buf.insert(line_buf.size(), rb);
            end
            if (shape < 20 || shape >= 25) line_buf.insert(line_buf.size(), CH_SPACE);

            verb = $urandom_range(0, N_PROTOS - 1);
            for (int k = 0; k < PROTO_LEN; k++)
                line_buf.insert(line_buf.size(), PROTO_CHARS[verb][k]);

            if (shape >= 25 && shape < 33) begin
                // Extra bytes after the version, sometimes as a further token.
                if ($urandom_range(0, 1) == 0) line_buf.insert(line_buf.size(), CH_SPACE);
                n = $urandom_range(1, 10);
                repeat (n) begin
                    rb = 8'($urandom_range(33, 126));
                    line_buf.insert(line_buf.size(), rb);
                end
            end else if (shape >= 33 && shape < 48) begin
                rb = 8'($urandom_range(0, 255));
                line_buf[$urandom_range(0, line_buf.size() - 1)] = rb;
            end else if (shape >= 48 && shape < 53) begin
                n = $urandom_range(1, 9);
                repeat (n) begin
                    if (line_buf.size() > 1) void'(line_buf.pop_back());
                end
            end
        end
        commit_line(hold);
    endtask

    // Reset, stimulus build, and the end-of-run decision.
    initial
    begin
        int line_no;
        // Directed lines: the byte extremes, a line with no space at all,
        // a final space, three spaces, and a complete line.
        line_buf.insert(line_buf.size(), 8'h00);
        commit_line(1'b0);
        line_buf.insert(line_buf.size(), 8'hFF);
        commit_line(1'b0);
        add_text("GET");
        commit_line(1'b0);
        add_text("POST ");
        commit_line(1'b0);
        add_text("   x");
        commit_line(1'b0);
        add_text("GET / HTTP/1.1");
        commit_line(1'b0);

        // The first random line is held back until the block has drained.
        line_no = 0;
        while (octet_backlog.size() < BYTE_TARGET) begin
            add_random_line(line_no == 0 || $urandom_range(0, 39) == 0);
            line_no++;
        end
        // The tail of the run goes with no idling and no waiting for results.
        for (int i = octet_backlog.size() - QUIET_TAIL; i < octet_backlog.size(); i++) begin
            octet_backlog[i].calm = 1'b1;
            octet_backlog[i].hold = 1'b0;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (octet_backlog.size() != 0 || drv_valid) @(posedge clk);
        while (line_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fault_count == 0 && line_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Monitor: at each rising edge the result handshake is checked against
    // the oldest verdict, and an accepted request is fed to the predictor.
    always @(posedge clk)
    begin
        verdict_t want;
        cycle_count++;
        octet_taken = rst_n && request_ch.valid && request_ch.ready;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (line_verdicts.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("cycle %0d: unexpected result status %0d method %0d",
                             cycle_count, result_ch.status, result_ch.method_kind);
            end else begin
                want = line_verdicts.pop_front();
                if (result_ch.status !== want.st || result_ch.method_kind !== want.kind)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("cycle %0d: status exp %0d got %0d, method exp %0d got %0d",
                                 cycle_count, want.st, result_ch.status,
                                 want.kind, result_ch.method_kind);
                end
            end
        end
        if (octet_taken) scan_byte(request_ch.line_byte, request_ch.last_byte);
    end

    // Driver: all inputs change at the falling edge. Idling comes in bursts,
    // its density set by a mode that changes now and then, with mode zero
    // giving stretches of no idling at all.
    always @(negedge clk)
    begin
        line_octet_t nxt;
        logic        give;
        if (cycle_count % 97 == 0) idle_mode = $urandom_range(0, 2);
        if (rst_n) begin
            if (!drv_valid || octet_taken) begin
                give = 1'b0;
                if (send_gap != 0) begin
                    send_gap--;
                end else if (octet_backlog.size() != 0) begin
                    if (octet_backlog[0].hold && line_verdicts.size() != 0) begin
                        // Hold off until every verdict so far has been returned.
                    end else if (!octet_backlog[0].calm && idle_mode != 0 &&
                                 $urandom_range(0, 9) < idle_mode * 2) begin
                        send_gap = $urandom_range(0, 3);
                    end else begin
                        give = 1'b1;
                    end
                end
                if (give) begin
                    nxt        = octet_backlog.pop_front();
                    drv_valid  = 1'b1;
                    drv_byte   = nxt.octet;
                    drv_last   = nxt.fin;
                    quiet_tail = nxt.calm;
                end else begin
                    drv_valid = 1'b0;
                end
            end

            if (take_gap != 0) begin
                take_gap--;
                drv_ready = 1'b0;
            end else if (!quiet_tail && idle_mode != 0 &&
                         $urandom_range(0, 9) < idle_mode * 2) begin
                take_gap  = $urandom_range(0, 3);
                drv_ready = 1'b0;
            end else begin
                drv_ready = 1'b1;
            end
        end
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/hrlc_pkg.sv
hdl/hrlc_req_if.sv
hdl/hrlc_res_if.sv
hdl/hrlc_scanner.sv
hdl/hrlc_out_stage.sv
hdl/http_request_line_checker.sv
sim/tb_top.sv
